[src/derf_pkg.sv]
// ----------------------------------------------------------------------------
// derf_pkg
// Shared widths, codes and command types of the dropping event ring FIFO.
// ----------------------------------------------------------------------------
package derf_pkg;

    // Storage geometry
    localparam int ADDR_BITS = 14;              // log2 of the largest ring
    localparam int EVT_BITS  = 64;              // bits kept of each record
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int PTR_W     = ADDR_BITS + 1;   // pointers carry one wrap bit

    // Fixed field widths
    localparam int FUNC_W = 1;
    localparam int EVT_W  = 64;
    localparam int OCC_W  = 15;
    localparam int CNT_W  = 32;
    localparam int SIZE_W = 4;

    // Size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd14;
    localparam logic [SIZE_W-1:0] MIN_LOG2   = 4'd8;

    // APB register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_SIZE = 1'b0;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // carry out the accepted operation
        logic load;   // move the pending result into the output register
    } t_cmd;

endpackage

[src/derf_if.sv]
// ----------------------------------------------------------------------------
// derf_if
// Valid/ready channels of the dropping event ring FIFO.
// ----------------------------------------------------------------------------
interface derf_in_if;
    logic                         valid;
    logic                         ready;
    logic [derf_pkg::FUNC_W-1:0]  func;
    logic [derf_pkg::EVT_W-1:0]   evt_in;

    modport source (output valid, output func, output evt_in, input ready);
    modport sink   (input valid, input func, input evt_in, output ready);
endinterface

interface derf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [derf_pkg::EVT_W-1:0]   evt_out;
    logic [derf_pkg::OCC_W-1:0]   occupancy;
    logic [derf_pkg::CNT_W-1:0]   drop_count;
    logic [derf_pkg::CNT_W-1:0]   produced_count;
    logic [derf_pkg::OCC_W-1:0]   peak_level;

    modport source (output valid, output ok, output evt_out, output occupancy,
                    output drop_count, output produced_count, output peak_level,
                    input ready);
    modport sink   (input valid, input ok, input evt_out, input occupancy,
                    input drop_count, input produced_count, input peak_level,
                    output ready);
endinterface

[src/dropping_event_ring_fifo.sv]
// ----------------------------------------------------------------------------
// dropping_event_ring_fifo
// Event ring FIFO that drops pushes when full and keeps traffic statistics.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one operation per transfer: func selects push (store evt_in)
//         or pop (return the oldest record).
//   o_out returns exactly one result per operation: ok, the popped record,
//         the occupancy before the operation, and the drop count, produced
//         count and peak fill level after it.
//   APB   holds one register, size_log2 at address 0 (values clamp to 8..14).
//         Writing it empties the ring and clears every counter; write it only
//         while no operation is in flight.
// Timing: an operation is taken and executed in S_IDLE and its result is loaded into
//   the output register from S_DONE, so the block takes no new operation until the
//   last result is loaded; this is set by the registered read of the record store,
//   which a pop must wait for. Output valid rises when the result is loaded.
// Reset: synchronous, active low; the ring comes up empty with size_log2 = 14
//   and all counters zero. No clearing pass is needed.
// Stall: while the receiver holds ready low, one further operation is still
//   taken and its result is held until the output register drains.
// ----------------------------------------------------------------------------
module dropping_event_ring_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    derf_in_if.sink                      i_in,
    derf_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [derf_pkg::APB_AW-1:0]  paddr,
    input  logic [derf_pkg::APB_DW-1:0]  pwdata,
    output logic [derf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import derf_pkg::*;

    t_cmd              cmd;
    logic              cfg_wr;
    logic              reg_hit;
    logic [SIZE_W-1:0] size;

    // Decode the register file: word index is paddr above the byte offset
    assign reg_hit = (paddr[APB_AW-1:2] == REG_SIZE);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DW'(size) : '0;

    derf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    derf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_in.func),
        .i_evt_in         (i_in.evt_in),
        .i_cfg_wr         (cfg_wr),
        .i_cfg_size       (pwdata[SIZE_W-1:0]),
        .o_size           (size),
        .o_ok             (o_out.ok),
        .o_evt_out        (o_out.evt_out),
        .o_occupancy      (o_out.occupancy),
        .o_drop_count     (o_out.drop_count),
        .o_produced_count (o_out.produced_count),
        .o_peak_level     (o_out.peak_level)
    );
endmodule

[src/derf_ram.sv]
// ----------------------------------------------------------------------------
// derf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module derf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/derf_ctrl.sv]
// ----------------------------------------------------------------------------
// derf_ctrl
// Handshake controller: takes one operation, then hands its result on.
// ----------------------------------------------------------------------------
module derf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output derf_pkg::t_cmd  o_cmd
);
    import derf_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    t_cmd   n_cmd;

    always_comb begin
        n_state     = r_state;
        n_cmd.exec  = 1'b0;
        n_cmd.load  = 1'b0;
        n_out_vld   = r_out_vld && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // advance once the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_cmd.load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = n_cmd;
endmodule

[src/derf_dp.sv]
// ----------------------------------------------------------------------------
// derf_dp
// Datapath: pointers, counters, size register, record store, result register.
// ----------------------------------------------------------------------------
module derf_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  derf_pkg::t_cmd               i_cmd,
    input  logic [derf_pkg::FUNC_W-1:0]  i_func,
    input  logic [derf_pkg::EVT_W-1:0]   i_evt_in,
    input  logic                         i_cfg_wr,
    input  logic [derf_pkg::SIZE_W-1:0]  i_cfg_size,
    output logic [derf_pkg::SIZE_W-1:0]  o_size,
    output logic                         o_ok,
    output logic [derf_pkg::EVT_W-1:0]   o_evt_out,
    output logic [derf_pkg::OCC_W-1:0]   o_occupancy,
    output logic [derf_pkg::CNT_W-1:0]   o_drop_count,
    output logic [derf_pkg::CNT_W-1:0]   o_produced_count,
    output logic [derf_pkg::OCC_W-1:0]   o_peak_level
);
    import derf_pkg::*;

    // Control state
    logic [SIZE_W-1:0] r_size;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_ref, n_ref;
    logic [PTR_W-1:0]  r_peak, n_peak;
    logic              r_pnd_ok;
    logic              r_pnd_pop;

    // Payload
    logic [PTR_W-1:0]  r_pnd_occ;
    logic              r_o_ok;
    logic [EVT_W-1:0]  r_o_evt;
    logic [OCC_W-1:0]  r_o_occ;
    logic [CNT_W-1:0]  r_o_drop;
    logic [CNT_W-1:0]  r_o_prod;
    logic [OCC_W-1:0]  r_o_hw;

    logic [SIZE_W-1:0]    lg;
    logic [PTR_W-1:0]     cap;
    logic [ADDR_BITS-1:0] mask;
    logic [PTR_W-1:0]     occ;
    logic [PTR_W-1:0]     occ_inc;
    logic                 full;
    logic                 empty;
    logic                 do_push;
    logic                 do_drop;
    logic                 do_pop;
    logic [EVT_BITS-1:0]  rdata;

    // Clamp the size to the supported range
    always_comb begin
        lg = r_size;
        if (r_size < MIN_LOG2) begin
            lg = MIN_LOG2;
        end else if (int'(r_size) > ADDR_BITS) begin
            lg = SIZE_W'(ADDR_BITS);
        end
    end

    assign cap     = PTR_W'(1) << lg;
    assign mask    = ADDR_BITS'(cap - PTR_W'(1));
    assign occ     = r_wp - r_rp;
    assign occ_inc = occ + PTR_W'(1);
    assign full    = (occ >= cap);
    assign empty   = (occ == '0);
    assign do_push = i_cmd.exec && (i_func == FUNC_PUSH) && !full;
    assign do_drop = i_cmd.exec && (i_func == FUNC_PUSH) && full;
    assign do_pop  = i_cmd.exec && (i_func == FUNC_POP) && !empty;

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_acc  = r_acc;
        n_ref  = r_ref;
        n_peak = r_peak;
        if (do_push) begin
            n_wp  = r_wp + PTR_W'(1);
            n_acc = r_acc + CNT_W'(1);
            if (occ_inc > r_peak) begin
                n_peak = occ_inc;
            end
        end
        if (do_drop) begin
            n_ref = r_ref + CNT_W'(1);
        end
        if (do_pop) begin
            n_rp = r_rp + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RESET;
            r_wp      <= '0;
            r_rp      <= '0;
            r_acc     <= '0;
            r_ref     <= '0;
            r_peak    <= '0;
            r_pnd_ok  <= 1'b0;
            r_pnd_pop <= 1'b0;
        end else if (i_cfg_wr) begin
            // new size: drop the ring contents and clear the counters
            r_size <= i_cfg_size;
            r_wp   <= '0;
            r_rp   <= '0;
            r_acc  <= '0;
            r_ref  <= '0;
            r_peak <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_acc  <= n_acc;
            r_ref  <= n_ref;
            r_peak <= n_peak;
            if (i_cmd.exec) begin
                r_pnd_ok  <= do_push || do_pop;
                r_pnd_pop <= do_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pnd_occ <= occ;
        end
        if (i_cmd.load) begin
            r_o_ok   <= r_pnd_ok;
            r_o_evt  <= r_pnd_pop ? EVT_W'(rdata) : '0;
            r_o_occ  <= OCC_W'(r_pnd_occ);
            r_o_drop <= r_ref;
            r_o_prod <= r_acc;
            r_o_hw   <= OCC_W'(r_peak);
        end
    end

    derf_ram #(
        .WIDTH (EVT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wp[ADDR_BITS-1:0] & mask),
        .i_wdata (i_evt_in[EVT_BITS-1:0]),
        .i_re    (do_pop),
        .i_raddr (r_rp[ADDR_BITS-1:0] & mask),
        .o_rdata (rdata)
    );

    assign o_size           = r_size;
    assign o_ok             = r_o_ok;
    assign o_evt_out        = r_o_evt;
    assign o_occupancy      = r_o_occ;
    assign o_drop_count     = r_o_drop;
    assign o_produced_count = r_o_prod;
    assign o_peak_level     = r_o_hw;
endmodule
